// ===== hdl/sha1_message_digest_core_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 digest core assertion macros
// Shared property forms for the core's checker; clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH

// same-cycle implication
`define SHA1MD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sha1md_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Types, constants and round helpers shared by the digest core modules.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned BLOCK_BITS  = BLOCK_WORDS * WORD_BITS;
   localparam int unsigned HASH_WORDS  = 5;

   typedef logic [WORD_BITS-1:0]                  word_type;
   typedef logic [HASH_WORDS-1:0][WORD_BITS-1:0]  hash_type;

   localparam logic [6:0] LAST_ROUND   = 7'd79;
   localparam logic [6:0] ROUND_GRP1   = 7'd20;
   localparam logic [6:0] ROUND_GRP2   = 7'd40;
   localparam logic [6:0] ROUND_GRP3   = 7'd60;
   localparam logic [5:0] LAST_FILL    = 6'd63;
   localparam logic [5:0] LEN_FILL     = 6'd56;
   localparam logic [2:0] LAST_WORD_NO = 3'd4;
   localparam logic [7:0] PAD_MARK     = 8'h80;

   localparam word_type K_GRP0 = 32'h5A827999;
   localparam word_type K_GRP1 = 32'h6ED9EBA1;
   localparam word_type K_GRP2 = 32'h8F1BBCDC;
   localparam word_type K_GRP3 = 32'hCA62C1D6;

   // element 0 is H0
   localparam hash_type H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         put;
      byte_sel_type byte_sel;
      logic         count_inc;
      logic         load;
      logic         step;
      logic [6:0]   round;
      logic         update;
      logic         clear;
      logic         rsp_valid;
      logic [2:0]   word;
   } ctrl_type;

   function automatic word_type rotl1(input word_type x);
      return {x[30:0], x[31]};
   endfunction

   function automatic word_type rotl5(input word_type x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic word_type rotl30(input word_type x);
      return {x[1:0], x[31:2]};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sha1md_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 digest channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message,
                   input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message,
                   output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, digest_word, word_number, last_word,
                   input ready);
   modport sink   (input valid, digest_word, word_number, last_word,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/sha1md_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 block buffer and message schedule
// Bytes shift in to form the 16-word block; during rounds the same register
// shifts by a word, producing W[t] at the top and W[t+16] at the bottom.
// ----------------------------------------------------------------------------
module sha1md_sched (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      put,
   input  wire logic [7:0]                put_byte,
   input  wire logic                      step,
   output sha1md_pkg::word_type           w_top,
   output logic [5:0]                     fill
);

   logic [sha1md_pkg::BLOCK_BITS-1:0] blk_ff;
   logic [5:0]                        fill_ff;
   sha1md_pkg::word_type              w2, w8, w13, w_new;

   // word k of the window sits k words below the top
   assign w_top = blk_ff[sha1md_pkg::BLOCK_BITS-1 -: 32];
   assign w2    = blk_ff[sha1md_pkg::BLOCK_BITS-1-2*32 -: 32];
   assign w8    = blk_ff[sha1md_pkg::BLOCK_BITS-1-8*32 -: 32];
   assign w13   = blk_ff[sha1md_pkg::BLOCK_BITS-1-13*32 -: 32];
   assign w_new = sha1md_pkg::rotl1(w13 ^ w8 ^ w2 ^ w_top);
   assign fill  = fill_ff;

   always_ff @(posedge clock) begin
      if (put) begin
         blk_ff <= {blk_ff[sha1md_pkg::BLOCK_BITS-9:0], put_byte};
      end else if (step) begin
         blk_ff <= {blk_ff[sha1md_pkg::BLOCK_BITS-33:0], w_new};
      end
   end

   // wraps at 64: the byte that fills the block returns it to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 6'd0;
      end else if (put) begin
         fill_ff <= fill_ff + 6'd1;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/sha1md_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working variables a..e with the shared round adder, and the chain value.
// ----------------------------------------------------------------------------
module sha1md_round (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sha1md_pkg::ctrl_type ctrl,
   input  wire sha1md_pkg::word_type w_top,
   output sha1md_pkg::hash_type      chain
);

   sha1md_pkg::hash_type chain_ff;
   sha1md_pkg::hash_type wv_ff;
   sha1md_pkg::word_type f_val, k_val, nxt;

   always_comb begin
      if (ctrl.round < sha1md_pkg::ROUND_GRP1) begin
         f_val = (wv_ff[1] & wv_ff[2]) | (~wv_ff[1] & wv_ff[3]);
         k_val = sha1md_pkg::K_GRP0;
      end else if (ctrl.round < sha1md_pkg::ROUND_GRP2) begin
         f_val = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
         k_val = sha1md_pkg::K_GRP1;
      end else if (ctrl.round < sha1md_pkg::ROUND_GRP3) begin
         f_val = (wv_ff[1] & wv_ff[2]) | (wv_ff[1] & wv_ff[3]) | (wv_ff[2] & wv_ff[3]);
         k_val = sha1md_pkg::K_GRP2;
      end else begin
         f_val = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
         k_val = sha1md_pkg::K_GRP3;
      end
      nxt = sha1md_pkg::rotl5(wv_ff[0]) + f_val + wv_ff[4] + k_val + w_top;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         wv_ff <= chain_ff;
      end else if (ctrl.step) begin
         wv_ff[0] <= nxt;
         wv_ff[1] <= wv_ff[0];
         wv_ff[2] <= sha1md_pkg::rotl30(wv_ff[1]);
         wv_ff[3] <= wv_ff[2];
         wv_ff[4] <= wv_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         chain_ff <= sha1md_pkg::H_INIT;
      end else if (ctrl.update) begin
         for (int i = 0; i < sha1md_pkg::HASH_WORDS; i++) begin
            chain_ff[i] <= chain_ff[i] + wv_ff[i];
         end
      end
   end

   assign chain = chain_ff;

endmodule
`default_nettype wire

// ===== hdl/sha1md_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 sequencer
// Takes bytes, runs the 80 rounds, feeds padding and steps out the digest.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_present,
   input  wire logic          req_end,
   input  wire logic [5:0]    fill,
   input  wire logic          rsp_ready,
   output logic               req_ready,
   output sha1md_pkg::ctrl_type ctrl
);

   sha1md_pkg::state_type state_ff, state_in;
   logic [6:0] round_ff;
   logic [2:0] word_ff;
   logic       mark_ff;   // 0x80 already appended
   logic       len_ff;    // length bytes under way
   logic       done_ff;   // final block queued
   logic       pend_ff;   // message ends after this compression
   logic       fill_last;

   assign fill_last = (fill == sha1md_pkg::LAST_FILL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_present && fill_last) begin
                  state_in = sha1md_pkg::ST_ROUND;
               end else if (req_end) begin
                  state_in = sha1md_pkg::ST_PAD;
               end
            end
         end
         sha1md_pkg::ST_ROUND: begin
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               state_in = sha1md_pkg::ST_UPDATE;
            end
         end
         sha1md_pkg::ST_UPDATE: begin
            if (done_ff) begin
               state_in = sha1md_pkg::ST_OUTPUT;
            end else if (pend_ff) begin
               state_in = sha1md_pkg::ST_PAD;
            end else begin
               state_in = sha1md_pkg::ST_IDLE;
            end
         end
         sha1md_pkg::ST_PAD: begin
            if (fill_last) begin
               state_in = sha1md_pkg::ST_ROUND;
            end
         end
         sha1md_pkg::ST_OUTPUT: begin
            if (rsp_ready && word_ff == sha1md_pkg::LAST_WORD_NO) begin
               state_in = sha1md_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1md_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      ctrl           = '0;
      ctrl.byte_sel  = sha1md_pkg::SEL_DATA;
      ctrl.round     = round_ff;
      ctrl.word      = word_ff;
      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            ctrl.put       = req_valid && req_present;
            ctrl.count_inc = req_valid && req_present;
            ctrl.load      = req_valid && req_present && fill_last;
         end
         sha1md_pkg::ST_ROUND: begin
            ctrl.step = 1'b1;
         end
         sha1md_pkg::ST_UPDATE: begin
            ctrl.update = 1'b1;
         end
         sha1md_pkg::ST_PAD: begin
            ctrl.put  = 1'b1;
            ctrl.load = fill_last;
            if (!mark_ff) begin
               ctrl.byte_sel = sha1md_pkg::SEL_MARK;
            end else if (len_ff || fill == sha1md_pkg::LEN_FILL) begin
               ctrl.byte_sel = sha1md_pkg::SEL_LEN;
            end else begin
               ctrl.byte_sel = sha1md_pkg::SEL_ZERO;
            end
         end
         sha1md_pkg::ST_OUTPUT: begin
            ctrl.rsp_valid = 1'b1;
            ctrl.clear     = rsp_ready && word_ff == sha1md_pkg::LAST_WORD_NO;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::ST_IDLE;
         round_ff <= 7'd0;
         word_ff  <= 3'd0;
         mark_ff  <= 1'b0;
         len_ff   <= 1'b0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.step && round_ff != sha1md_pkg::LAST_ROUND) begin
            round_ff <= round_ff + 7'd1;
         end else begin
            round_ff <= 7'd0;
         end
         if (ctrl.clear) begin
            word_ff <= 3'd0;
         end else if (ctrl.rsp_valid && rsp_ready) begin
            word_ff <= word_ff + 3'd1;
         end
         if (state_ff == sha1md_pkg::ST_IDLE && req_valid) begin
            pend_ff <= req_end;
         end
         if (ctrl.clear) begin
            mark_ff <= 1'b0;
            len_ff  <= 1'b0;
            done_ff <= 1'b0;
         end else if (state_ff == sha1md_pkg::ST_PAD) begin
            if (ctrl.byte_sel == sha1md_pkg::SEL_MARK) begin
               mark_ff <= 1'b1;
            end
            if (ctrl.byte_sel == sha1md_pkg::SEL_LEN) begin
               len_ff <= 1'b1;
               if (fill_last) begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/sha1_message_digest_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Byte-serial SHA-1: buffers 64-byte blocks, compresses one round per
// cycle, pads at end of message and returns the 160-bit digest as five words.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | transaction
//  ---------+-----+------------------------------------------+---------------------------
//  req_ch   | in  | data_byte, byte_present, end_of_message  | one byte and/or end mark
//  rsp_ch   | out | digest_word, word_number, last_word      | one digest word, H0 first
//
//  The byte that completes a block adds the rounds on the shared round adder
//  plus a chain update.
//  An end-of-message transaction feeds padding one byte a cycle (up to 72),
//  with one or two compressions, then offers five digest transactions.
//  req_ch is not ready while rounds, padding or digest output are under way.
//  Reset is synchronous; the block buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
   input  wire logic    clock,
   input  wire logic    reset,
   sha1md_req_if.sink   req_ch,
   sha1md_rsp_if.source rsp_ch
);

   sha1md_pkg::ctrl_type ctrl;
   sha1md_pkg::word_type w_top;
   sha1md_pkg::hash_type chain;
   logic [5:0]           fill;
   logic [7:0]           put_byte;
   logic [60:0]          count_ff;   // message bytes, wraps modulo 2^61
   logic [63:0]          len_bits;

   // sequencer
   sha1md_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_present (req_ch.byte_present),
      .req_end     (req_ch.end_of_message),
      .fill        (fill),
      .rsp_ready   (rsp_ch.ready),
      .req_ready   (req_ch.ready),
      .ctrl        (ctrl)
   );

   // block buffer doubles as the message schedule window
   sha1md_sched u_sched (
      .clock    (clock),
      .reset    (reset),
      .put      (ctrl.put),
      .put_byte (put_byte),
      .step     (ctrl.step),
      .w_top    (w_top),
      .fill     (fill)
   );

   // round unit and chain value
   sha1md_round u_round (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .w_top (w_top),
      .chain (chain)
   );

   // byte count; the bit length is the count shifted left by three
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         count_ff <= 61'd0;
      end else if (ctrl.count_inc) begin
         count_ff <= count_ff + 61'd1;
      end
   end

   assign len_bits = {count_ff, 3'b000};

   // byte source: message data, the 0x80 mark, zero fill, or the length,
   // big-endian, indexed by the low bits of the fill position
   always_comb begin
      case (ctrl.byte_sel)
         sha1md_pkg::SEL_DATA: put_byte = req_ch.data_byte;
         sha1md_pkg::SEL_MARK: put_byte = sha1md_pkg::PAD_MARK;
         sha1md_pkg::SEL_ZERO: put_byte = 8'h00;
         sha1md_pkg::SEL_LEN:  put_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
         default:              put_byte = 8'h00;
      endcase
   end

   // digest words come straight from the chain registers
   assign rsp_ch.valid       = ctrl.rsp_valid;
   assign rsp_ch.digest_word = chain[ctrl.word];
   assign rsp_ch.word_number = ctrl.word;
   assign rsp_ch.last_word   = (ctrl.word == sha1md_pkg::LAST_WORD_NO);

endmodule
`default_nettype wire

// ===== hdl/sha1md_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 digest core checker
// Port-level properties of the digest core, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_core_macros.svh"

module sha1md_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] digest_word,
   input wire logic [2:0]  word_number,
   input wire logic        last_word
);

   `SHA1MD_ASSERT_SAME(a_no_take_in_output, rsp_valid, !req_ready, "input taken during digest output")
   `SHA1MD_ASSERT_SAME(a_first_word, $rose(rsp_valid), word_number == 3'd0, "digest does not start at word 0")
   `SHA1MD_ASSERT_NEXT(a_word_order, rsp_valid && rsp_ready && !last_word, rsp_valid && word_number == $past(word_number) + 3'd1, "digest words out of order")
   `SHA1MD_ASSERT_NEXT(a_back_to_idle, rsp_valid && rsp_ready && last_word, req_ready && !rsp_valid, "not ready after last digest word")
   `SHA1MD_ASSERT_NEXT(a_hold_stall, rsp_valid && !rsp_ready, rsp_valid && $stable(digest_word), "digest word changed while stalled")

endmodule

bind sha1_message_digest_core sha1md_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .digest_word (rsp_ch.digest_word),
   .word_number (rsp_ch.word_number),
   .last_word   (rsp_ch.last_word)
);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest core testbench
// Directed table, then random messages of mixed lengths, with random idling
// on both channels. Every digest transaction is checked field by field against
// a bit-accurate SHA-1 predictor in the testbench, or a row's typed digest.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          CLOCK_PERIOD    = 10;
   localparam int          RESET_CYCLES    = 4;
   localparam int unsigned MAX_GAP         = 16;
   localparam int unsigned RANDOM_ITEMS    = 300;
   // receiver hold-off: starts after this many digest words have been taken
   localparam int unsigned HOLD_AT_WORD    = 22;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   // random message at whose end the sender waits for the digest to drain
   localparam int unsigned PAUSE_AT_MSG    = 3;
   // longest correct silence: hold-off, padding plus two compressions, gaps;
   // the limit takes that several times over
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   // after the last digest word: room for any stray late transaction
   localparam int unsigned DRAIN_CYCLES    = 300;

   // digests that can be read straight off the standard
   localparam logic [159:0] EMPTY_DIGEST =
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_DIGEST =
      160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

   // one row of directed stimulus; digest is used only where digest_known
   typedef struct packed {
      logic [7:0]   data_byte;
      logic         byte_present;
      logic         end_of_message;
      logic         digest_known;
      logic [159:0] digest;
   } stim_row_type;

   // one digest transaction as it should appear on rsp_ch
   typedef struct packed {
      sha1md_pkg::word_type digest_word;
      logic [2:0]           word_number;
      logic                 last_word;
   } digest_txn_type;

   localparam int NUM_DIRECTED = 11;
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // empty message straight after reset
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      // "abc", last byte and end mark in one transaction
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'd0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'd0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      // byte extremes, with ignored items carrying all-ones / mixed data
      '{8'h00, 1'b1, 1'b0, 1'b0, 160'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 160'd0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 160'd0},
      '{8'hA5, 1'b0, 1'b0, 1'b0, 160'd0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 160'd0},
      // end mark on its own after a byte
      '{8'h55, 1'b1, 1'b0, 1'b0, 160'd0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 160'd0}
   };

   logic clock;
   logic reset;

   sha1md_req_if req_ch ();
   sha1md_rsp_if rsp_ch ();

   sha1_message_digest_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // --------------------------------------------------------------------------
   // Predictor state: chain value, block buffer, fill and byte count
   // --------------------------------------------------------------------------
   sha1md_pkg::word_type hash_chain [5];
   logic [7:0]           msg_block [64];
   int unsigned          block_fill;
   logic [60:0]          msg_byte_count;

   digest_txn_type digest_words_due [$];
   int unsigned    mismatches;
   int unsigned    quiet_cycles;

   // sideband travelling with each request: typed digest for the table rows
   logic         row_digest_known;
   logic [159:0] row_digest;

   function automatic sha1md_pkg::word_type rol32(input sha1md_pkg::word_type x,
                                                  input int unsigned s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic void restart_digest_state();
      hash_chain[0]  = 32'h67452301;
      hash_chain[1]  = 32'hEFCDAB89;
      hash_chain[2]  = 32'h98BADCFE;
      hash_chain[3]  = 32'h10325476;
      hash_chain[4]  = 32'hC3D2E1F0;
      block_fill     = 0;
      msg_byte_count = '0;
   endfunction

   // 80-round compression of the full block buffer into the chain value
   function automatic void sha1_compress_block();
      sha1md_pkg::word_type sched [80];
      sha1md_pkg::word_type a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++)
         sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (int r = 16; r < 80; r++)
         sched[r] = rol32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rol32(a, 5) + f + e + k + sched[r];
         e = d;
         d = c;
         c = rol32(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   function automatic void append_block_byte(input logic [7:0] value);
      msg_block[block_fill] = value;
      block_fill++;
      if (block_fill == 64) begin
         sha1_compress_block();
         block_fill = 0;
      end
   endfunction

   // Takes one accepted request; on an end mark pads, finishes and queues
   // the five digest words (typed digest instead where the row gives one).
   function automatic void absorb_message_item(input logic [7:0] data_byte,
                                               input logic byte_present,
                                               input logic end_of_message,
                                               input logic use_typed,
                                               input logic [159:0] typed_digest);
      logic [63:0]    bit_length;
      digest_txn_type txn;
      if (byte_present) begin
         msg_byte_count = msg_byte_count + 61'd1;
         append_block_byte(data_byte);
      end
      if (!end_of_message) return;
      bit_length = {msg_byte_count, 3'b000};
      append_block_byte(8'h80);
      while (block_fill != 56) append_block_byte(8'h00);
      for (int i = 0; i < 8; i++) append_block_byte(bit_length[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
         txn.digest_word = use_typed ? typed_digest[159 - 32*i -: 32] : hash_chain[i];
         txn.word_number = 3'(i);
         txn.last_word   = (3'(i) == sha1md_pkg::LAST_WORD_NO);
         digest_words_due.push_back(txn);
      end
      restart_digest_state();
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_digest_word();
      digest_txn_type want;
      if (digest_words_due.size() == 0) begin
         report_mismatch("unexpected digest transaction", rsp_ch.digest_word, '0);
         return;
      end
      want = digest_words_due.pop_front();
      if (rsp_ch.digest_word !== want.digest_word)
         report_mismatch("digest_word", rsp_ch.digest_word, want.digest_word);
      if (rsp_ch.word_number !== want.word_number)
         report_mismatch("word_number", 32'(rsp_ch.word_number), 32'(want.word_number));
      if (rsp_ch.last_word !== want.last_word)
         report_mismatch("last_word", 32'(rsp_ch.last_word), 32'(want.last_word));
   endtask

   // --------------------------------------------------------------------------
   // Monitor: every transaction on either channel is seen here. Inputs are
   // driven with nonblocking assignments, so the values read are those at
   // the edge.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) check_digest_word();
         if (req_ch.valid && req_ch.ready)
            absorb_message_item(req_ch.data_byte, req_ch.byte_present,
                                req_ch.end_of_message, row_digest_known, row_digest);
      end
   end

   // Watchdog: counts edges with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: random stall before each digest word, with burst stretches of
   // no stall, and one long hold-off that backs the core up so that req_ch
   // stalls while the sender keeps offering.
   // --------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      int unsigned words_taken;
      bit          burst;
      rsp_ch.ready <= 1'b0;
      words_taken = 0;
      burst       = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (words_taken % 5 == 0) burst = ($urandom_range(0, 3) == 0);
         stall = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (words_taken == HOLD_AT_WORD) stall = HOLD_OFF_CYCLES;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         words_taken++;
      end
   end

   // --------------------------------------------------------------------------
   // Sender
   // --------------------------------------------------------------------------

   // Offers one request after a random gap and returns at its accepting edge.
   // valid is only lowered when a gap follows, so back-to-back transactions
   // keep it high.
   task automatic offer_request(input logic [7:0] data_byte, input logic byte_present,
                                input logic end_of_message, input logic digest_known,
                                input logic [159:0] digest, input bit burst);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= data_byte;
      req_ch.byte_present   <= byte_present;
      req_ch.end_of_message <= end_of_message;
      row_digest_known      <= digest_known;
      row_digest            <= digest;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Sender stops offering until every queued digest word has come back.
   task automatic wait_digest_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (digest_words_due.size() != 0) @(posedge clock);
   endtask

   // Message lengths: mostly short, the rest around the padding boundaries
   // (55/56 bytes decide one or two padding blocks, 64 fills a block).
   function automatic int unsigned pick_message_length();
      int unsigned boundary_lengths [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 12);
      return boundary_lengths[$urandom_range(0, 9)];
   endfunction

   // Sends one random message and returns the number of items offered
   // (bytes, noise items and the end mark).
   task automatic send_random_message(output int unsigned items_sent);
      int unsigned msg_len;
      bit          burst;
      bit          joint_end;
      msg_len    = pick_message_length();
      burst      = ($urandom_range(0, 3) == 0);
      joint_end  = (msg_len != 0) && ($urandom_range(0, 1) == 1);
      items_sent = 0;
      for (int unsigned i = 0; i < msg_len; i++) begin
         // noise: a transaction with no byte and no end mark
         if ($urandom_range(0, 9) == 0) begin
            offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0, burst);
            items_sent++;
         end
         offer_request(8'($urandom_range(0, 255)), 1'b1,
                       joint_end && (i == msg_len - 1), 1'b0, '0, burst);
         items_sent++;
      end
      if (!joint_end) begin
         offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0, burst);
         items_sent++;
      end
   endtask

   initial begin
      int unsigned random_items;
      int unsigned msg_items;
      int unsigned msg_index;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.data_byte      <= 8'h00;
      req_ch.byte_present   <= 1'b0;
      req_ch.end_of_message <= 1'b0;
      row_digest_known      <= 1'b0;
      row_digest            <= '0;
      mismatches   = 0;
      restart_digest_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < NUM_DIRECTED; r++)
         offer_request(DIRECTED_ROWS[r].data_byte, DIRECTED_ROWS[r].byte_present,
                       DIRECTED_ROWS[r].end_of_message, DIRECTED_ROWS[r].digest_known,
                       DIRECTED_ROWS[r].digest, 1'b0);
      wait_digest_drained();

      // random messages; the receiver's hold-off lands in the first of these
      random_items = 0;
      msg_index    = 0;
      while (random_items < RANDOM_ITEMS) begin
         send_random_message(msg_items);
         random_items += msg_items;
         msg_index++;
         if (msg_index == PAUSE_AT_MSG) wait_digest_drained();
      end

      // drain, then leave room for anything the core should not send
      wait_digest_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && digest_words_due.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sha1md_pkg.sv
hdl/sha1md_if.sv
hdl/sha1md_sched.sv
hdl/sha1md_round.sv
hdl/sha1md_ctrl.sv
hdl/sha1_message_digest_core.sv
hdl/sha1md_checker.sv
dv/testbench.sv
